>>> rtl/srtclp_pkg.sv
package srtclp_pkg;

   localparam int LINE_LENGTH_BITS_DEFAULT = 16;

   localparam int BYTE_BITS      = 8;
   localparam int TIME_BITS      = 44;
   localparam int SUM_BITS       = 45;
   localparam int WEIGHT_BITS    = 37;
   localparam int DIGIT_BITS     = 9;
   localparam int LENGTH_BITS    = 16;
   localparam int RSP_DATA_BITS  = 112;

   localparam int ARROW_AT       = 12;
   localparam int STOP_AT        = 17;
   localparam int TIMING_MIN_LEN = 29;

   localparam logic [BYTE_BITS-1:0] CHAR_CR   = 8'd13;
   localparam logic [BYTE_BITS-1:0] CHAR_LF   = 8'd10;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO = 8'd48;

   typedef enum logic [1:0] {
      LINE_TIMING   = 2'd0,
      LINE_CUE_TEXT = 2'd1,
      LINE_PRE_CUE  = 2'd2
   } line_kind_type;

   typedef struct packed {
      line_kind_type                kind;
      logic signed [TIME_BITS-1:0]  start_us;
      logic signed [TIME_BITS-1:0]  stop_us;
      logic [LENGTH_BITS-1:0]       length;
      logic                         all_digits;
      logic                         stop_before_start;
   } line_result_type;

   // Weight of each byte of HH:MM:SS,mmm in microseconds; separators weigh nothing.
   function automatic logic signed [WEIGHT_BITS-1:0] weight_us(input logic [3:0] idx);
      logic signed [WEIGHT_BITS-1:0] w;
      case (idx)
         4'd0:    w = 37'sd36000000000;
         4'd1:    w = 37'sd3600000000;
         4'd3:    w = 37'sd600000000;
         4'd4:    w = 37'sd60000000;
         4'd6:    w = 37'sd10000000;
         4'd7:    w = 37'sd1000000;
         4'd9:    w = 37'sd100000;
         4'd10:   w = 37'sd10000;
         4'd11:   w = 37'sd1000;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [BYTE_BITS-1:0] arrow_char(input logic [2:0] idx);
      logic [BYTE_BITS-1:0] c;
      case (idx)
         3'd1:    c = 8'h2D;
         3'd2:    c = 8'h2D;
         3'd3:    c = 8'h3E;
         default: c = 8'h20;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/srt_cue_line_parser.sv
// A result passes two registers on its way out: the request that ends its line enters an input
// register, and its result is then captured in a result register, from which it is presented.
// Throughput: one request per cycle; a request that ends a line waits only while an earlier
// result is still held and not taken in the same cycle.
// Reset is synchronous and active high; it empties the input and result registers
// and returns the line state and the cue flag to their initial values.
module srt_cue_line_parser
   import srtclp_pkg::*;
#(
   parameter int LINE_LENGTH_BITS = LINE_LENGTH_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_BITS-1:0]      req_tdata,   // byte_value
   input  logic                      req_tlast,   // end_of_input
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // start_us, stop_us, line_length, all_digits, stop_before_start, zero fill.
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic [1:0]                rsp_tuser    // line_kind
);

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0]  in_byte_ff, in_byte_in;
   logic                  in_last_ff, in_last_in;
   logic                  out_valid_ff, out_valid_in;
   line_result_type       out_result_ff, out_result_in;

   logic                  emit;
   line_result_type       result;
   logic                  drain;

   srtclp_line_state #(
      .LINE_LENGTH_BITS(LINE_LENGTH_BITS)
   ) u_line_state (
      .clock        (clock),
      .reset        (reset),
      .step         (drain),
      .byte_value   (in_byte_ff),
      .end_of_input (in_last_ff),
      .emit         (emit),
      .result       (result)
   );

   always_comb begin
      drain = in_valid_ff && (!emit || !out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || drain;

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end

      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (drain && emit) begin
         out_valid_in  = 1'b1;
         out_result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff    <= in_byte_in;
      in_last_ff    <= in_last_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.kind;
   assign rsp_tdata  = {6'b0,
                        out_result_ff.stop_before_start,
                        out_result_ff.all_digits,
                        out_result_ff.length,
                        out_result_ff.stop_us,
                        out_result_ff.start_us};

endmodule

>>> rtl/srtclp_line_state.sv
module srtclp_line_state
   import srtclp_pkg::*;
#(
   parameter int LINE_LENGTH_BITS = LINE_LENGTH_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [BYTE_BITS-1:0]  byte_value,
   input  logic                  end_of_input,
   output logic                  emit,
   output line_result_type       result
);

   localparam int P = LINE_LENGTH_BITS;
   localparam int WIDE_BITS = (P > LENGTH_BITS) ? P : LENGTH_BITS;
   localparam logic [P-1:0] POS_MAX = {P{1'b1}};

   logic [P-1:0]                pos_ff, pos_in;
   logic                        acr_ff, acr_in;
   logic                        arrow_ff, arrow_in;
   logic                        digits_ff, digits_in;
   logic signed [SUM_BITS-1:0]  start_ff, start_in;
   logic signed [SUM_BITS-1:0]  stop_ff, stop_in;
   logic                        cue_ff, cue_in;

   logic                        is_cr, is_lf, is_text;
   logic                        in_start, in_arrow, in_stop;
   logic [P-1:0]                pos_rel_arrow, pos_rel_stop;
   logic [3:0]                  weight_idx;
   logic signed [DIGIT_BITS-1:0] digit;
   logic signed [SUM_BITS:0]    term;
   logic [P-1:0]                pos_take;
   logic                        arrow_take, digits_take;
   logic signed [SUM_BITS-1:0]  start_take, stop_take;
   logic [P-1:0]                src_pos;
   logic                        src_arrow, src_digits;
   logic signed [SUM_BITS-1:0]  src_start, src_stop;
   logic                        timing;
   logic [WIDE_BITS-1:0]        pos_wide;

   always_comb begin
      is_cr   = (byte_value == CHAR_CR);
      is_lf   = (byte_value == CHAR_LF);
      is_text = !is_cr && !is_lf;

      in_start = (pos_ff < P'(ARROW_AT));
      in_arrow = !in_start && (pos_ff < P'(STOP_AT));
      in_stop  = (pos_ff >= P'(STOP_AT)) && (pos_ff < P'(TIMING_MIN_LEN));
      pos_rel_arrow = pos_ff - P'(ARROW_AT);
      pos_rel_stop  = pos_ff - P'(STOP_AT);
      weight_idx = in_start ? pos_ff[3:0] : pos_rel_stop[3:0];

      digit = signed'({1'b0, byte_value}) - signed'({1'b0, CHAR_ZERO});
      term  = (SUM_BITS+1)'(digit) * (SUM_BITS+1)'(weight_us(weight_idx));

      start_take = start_ff + (in_start ? term[SUM_BITS-1:0] : '0);
      stop_take  = stop_ff + (in_stop ? term[SUM_BITS-1:0] : '0);
      arrow_take = arrow_ff && !(in_arrow && (byte_value != arrow_char(pos_rel_arrow[2:0])));
      digits_take = digits_ff && (byte_value inside {[8'h30:8'h39]});
      pos_take = (pos_ff == POS_MAX) ? pos_ff : pos_ff + P'(1);

      src_pos    = is_text ? pos_take : pos_ff;
      src_arrow  = is_text ? arrow_take : arrow_ff;
      src_digits = is_text ? digits_take : digits_ff;
      src_start  = is_text ? start_take : start_ff;
      src_stop   = is_text ? stop_take : stop_ff;

      emit   = is_cr || (is_lf && !acr_ff) || (is_text && end_of_input);
      timing = src_arrow && (src_pos >= P'(TIMING_MIN_LEN));

      pos_wide = WIDE_BITS'(src_pos);
      result.kind = timing ? LINE_TIMING : (cue_ff ? LINE_CUE_TEXT : LINE_PRE_CUE);
      result.start_us = timing ? src_start[TIME_BITS-1:0] : '0;
      result.stop_us  = timing ? src_stop[TIME_BITS-1:0] : '0;
      result.length = (pos_wide > WIDE_BITS'({LENGTH_BITS{1'b1}}))
                    ? {LENGTH_BITS{1'b1}} : pos_wide[LENGTH_BITS-1:0];
      result.all_digits = src_digits;
      result.stop_before_start = timing && (src_stop < src_start);
   end

   always_comb begin
      pos_in    = pos_ff;
      acr_in    = acr_ff;
      arrow_in  = arrow_ff;
      digits_in = digits_ff;
      start_in  = start_ff;
      stop_in   = stop_ff;
      cue_in    = cue_ff;
      if (step) begin
         if (end_of_input) begin
            pos_in    = '0;
            acr_in    = 1'b0;
            arrow_in  = 1'b1;
            digits_in = 1'b1;
            start_in  = '0;
            stop_in   = '0;
            cue_in    = 1'b0;
         end else if (is_text) begin
            pos_in    = pos_take;
            acr_in    = 1'b0;
            arrow_in  = arrow_take;
            digits_in = digits_take;
            start_in  = start_take;
            stop_in   = stop_take;
         end else begin
            acr_in = is_cr;
            if (emit) begin
               pos_in    = '0;
               arrow_in  = 1'b1;
               digits_in = 1'b1;
               start_in  = '0;
               stop_in   = '0;
               cue_in    = cue_ff || timing;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         acr_ff    <= 1'b0;
         arrow_ff  <= 1'b1;
         digits_ff <= 1'b1;
         start_ff  <= '0;
         stop_ff   <= '0;
         cue_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         acr_ff    <= acr_in;
         arrow_ff  <= arrow_in;
         digits_ff <= digits_in;
         start_ff  <= start_in;
         stop_ff   <= stop_in;
         cue_ff    <= cue_in;
      end
   end

endmodule
